// ----- rtl/idiv_pkg.sv -----
// Shared types for the iterative integer divider: controller states and datapath commands.
package idiv_pkg;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} idiv_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} idiv_cmd_t;

endpackage

// ----- rtl/idiv_dp.sv -----
// Datapath of the divider: operand magnitudes, shift-subtract loop and result registers.
module idiv_dp #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  idiv_pkg::idiv_cmd_t   cmd,
	input  logic                  op,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder,
	output logic                  divide_by_zero
);
	import idiv_pkg::*;

	logic                  neg_n;
	logic                  neg_d;
	logic [DATA_WIDTH-1:0] mag_n;
	logic [DATA_WIDTH-1:0] mag_d;
	logic [DATA_WIDTH:0]   shifted;
	logic [DATA_WIDTH:0]   diff;
	logic                  ge;

	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] den_q;
	logic                  qneg_q;
	logic                  op_q;
	logic                  dz_q;
	logic [DATA_WIDTH-1:0] quo_out_q;
	logic [DATA_WIDTH-1:0] rem_out_q;
	logic                  dz_out_q;

	always_comb begin
		neg_n   = op & dividend[DATA_WIDTH-1];
		neg_d   = op & divisor[DATA_WIDTH-1];
		mag_n   = neg_n ? ('0 - dividend) : dividend;
		mag_d   = neg_d ? ('0 - divisor) : divisor;
		// Partial remainder stays below the divisor, so one extra bit covers the shift.
		shifted = {rem_q, acc_q[DATA_WIDTH-1]};
		diff    = shifted - {1'b0, den_q};
		ge      = ~diff[DATA_WIDTH];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= '0;
			acc_q  <= mag_n;
			den_q  <= mag_d;
			qneg_q <= neg_n ^ neg_d;
			op_q   <= op;
			dz_q   <= (divisor == '0);
		end else if (cmd.step) begin
			rem_q <= ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
			acc_q <= {acc_q[DATA_WIDTH-2:0], ge};
		end
		if (cmd.finish) begin
			if (dz_q) begin
				quo_out_q <= '0;
			end else if (qneg_q) begin
				quo_out_q <= '0 - acc_q;
			end else begin
				quo_out_q <= acc_q;
			end
			rem_out_q <= (dz_q | op_q) ? '0 : rem_q;
			dz_out_q  <= dz_q;
		end
	end

	assign quotient       = quo_out_q;
	assign remainder      = rem_out_q;
	assign divide_by_zero = dz_out_q;

endmodule

// ----- rtl/idiv_ctrl.sv -----
// Controller of the divider: request and response handshakes and the step counter.
module idiv_ctrl #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output idiv_pkg::idiv_cmd_t cmd
);
	import idiv_pkg::*;

	localparam int CW = $clog2(DATA_WIDTH);

	idiv_state_t state_q;
	idiv_state_t state_d;
	logic [CW-1:0] cnt_q;
	logic          rsp_valid_q;
	logic          accept;
	logic          out_free;

	always_comb begin
		req_stall  = (state_q != ST_IDLE);
		accept     = req_valid & ~req_stall;
		out_free   = ~rsp_valid_q | ~rsp_stall;
		cmd.load   = accept;
		cmd.step   = (state_q == ST_RUN);
		cmd.finish = (state_q == ST_DONE) & out_free;
		state_d    = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (cnt_q == '0) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= CW'(DATA_WIDTH - 1);
			end else if (cmd.step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (~rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ----- rtl/integer_divider_signed_unsigned.sv -----
// The radix-2 shift-subtract loop takes one quotient bit per cycle: operand magnitudes are
// loaded when a request is accepted, and the sign is fixed as the result is written to the
// output register. New requests are stalled until the previous result is in that register.
// A finished result sits in the output register, so a new request can start while it waits.
// Reset (arst_n, asynchronous, active low) clears the controller state and response valid;
// data registers are not reset.
module integer_divider_signed_unsigned #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  op,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder,
	output logic                  divide_by_zero
);
	import idiv_pkg::*;

	// Commands from the controller to the datapath. The controller owns the
	// handshakes and counts the loop; the datapath only follows its commands.
	idiv_cmd_t cmd;

	idiv_ctrl #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// The datapath works on magnitudes: in signed mode the operands are negated
	// when negative, the unsigned quotient is built one bit per step, and it is
	// negated at the end when the operand signs differ. A zero divisor forces
	// quotient and remainder to zero and raises the error flag. Signed mode
	// reports a zero remainder.
	idiv_dp #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.op             (op),
		.dividend       (dividend),
		.divisor        (divisor),
		.quotient       (quotient),
		.remainder      (remainder),
		.divide_by_zero (divide_by_zero)
	);

`ifndef SYNTHESIS
	// A result must never overwrite one that is still waiting to be taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(rsp_valid && rsp_stall))
		else $error("result written over a pending response");

	// Only one request is in flight: after acceptance the input side is stalled.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while another is in work");

	// A divide-by-zero response carries zero quotient and remainder.
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && divide_by_zero) |-> (quotient == '0 && remainder == '0))
		else $error("divide by zero with nonzero result");
`endif

endmodule

// ----- sim/div_op_pkg.sv -----
// Operation codes of the divider requests, shared by the testbench top and the checker.
package div_op_pkg;

	typedef enum logic {
		OP_UNSIGNED = 1'b0,
		OP_SIGNED   = 1'b1
	} div_op_t;

endpackage

// ----- sim/div_result_checker.sv -----
// Checker for the divider: predicts each response from the accepted requests and compares.
module div_result_checker #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	input  logic         req_stall,
	input  logic         op,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	input  logic         rsp_valid,
	input  logic         rsp_stall,
	input  logic [W-1:0] quotient,
	input  logic [W-1:0] remainder,
	input  logic         divide_by_zero,
	output int           mismatches,
	output int           awaiting
);
	timeunit 1ns;
	timeprecision 1ps;

	import div_op_pkg::*;

	typedef struct {
		logic [W-1:0] quo;
		logic [W-1:0] rem;
		logic         dbz;
	} div_result_t;

	div_result_t pending_results[$];
	div_result_t want;
	int          err_count = 0;

	// Signed mode divides magnitudes; the most negative value keeps its own bit pattern
	// as magnitude, which read unsigned is the right one.
	function automatic div_result_t predict_division(div_op_t o, logic [W-1:0] n,
			logic [W-1:0] d);
		div_result_t  r;
		logic         neg_n;
		logic         neg_d;
		logic [W-1:0] mag_n;
		logic [W-1:0] mag_d;
		r.quo = '0;
		r.rem = '0;
		r.dbz = 1'b0;
		if (d == '0) begin
			r.dbz = 1'b1;
		end else if (o == OP_UNSIGNED) begin
			r.quo = n / d;
			r.rem = n % d;
		end else begin
			neg_n = n[W-1];
			neg_d = d[W-1];
			mag_n = neg_n ? -n : n;
			mag_d = neg_d ? -d : d;
			r.quo = mag_n / mag_d;
			if (neg_n != neg_d)
				r.quo = -r.quo;
		end
		return r;
	endfunction

	initial begin
		mismatches = 0;
		awaiting = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			// Responses are matched before this edge's request is queued.
			if (rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected response: expected none, got q=%h r=%h dbz=%b",
						$time, quotient, remainder, divide_by_zero);
					err_count++;
				end else begin
					want = pending_results.pop_front();
					if (quotient !== want.quo) begin
						$display("%0t: quotient mismatch: expected %h, got %h",
							$time, want.quo, quotient);
						err_count++;
					end
					if (remainder !== want.rem) begin
						$display("%0t: remainder mismatch: expected %h, got %h",
							$time, want.rem, remainder);
						err_count++;
					end
					if (divide_by_zero !== want.dbz) begin
						$display("%0t: divide_by_zero mismatch: expected %b, got %b",
							$time, want.dbz, divide_by_zero);
						err_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				pending_results.push_back(predict_division(div_op_t'(op), dividend, divisor));
		end
		mismatches <= err_count;
		awaiting <= pending_results.size();
	end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the integer divider: drives requests, paces responses, gives the verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import div_op_pkg::*;

	localparam int W              = 32;
	localparam int RANDOM_ITEMS   = 1000;
	// The receiver stops taking responses for a long stretch once, after this many.
	localparam int HOLD_AT        = 40;
	localparam int HOLD_CYCLES    = 400;
	// The longest legitimate quiet stretch is the long hold plus one division.
	localparam int WATCHDOG_LIMIT = 2000;
	// Latency of one division plus margin, waited out before the verdict.
	localparam int DRAIN_CYCLES   = 50;

	logic         clk;
	logic         arst_n;
	logic         req_valid;
	logic         req_stall;
	logic         op;
	logic [W-1:0] dividend;
	logic [W-1:0] divisor;
	logic         rsp_valid;
	logic         rsp_stall;
	logic [W-1:0] quotient;
	logic [W-1:0] remainder;
	logic         divide_by_zero;

	int mismatches;
	int awaiting;
	int idle_run;
	bit tx_steady;

	integer_divider_signed_unsigned #(
		.DATA_WIDTH(W)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.op             (op),
		.dividend       (dividend),
		.divisor        (divisor),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.quotient       (quotient),
		.remainder      (remainder),
		.divide_by_zero (divide_by_zero)
	);

	div_result_checker #(
		.W(W)
	) u_result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.op             (op),
		.dividend       (dividend),
		.divisor        (divisor),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.quotient       (quotient),
		.remainder      (remainder),
		.divide_by_zero (divide_by_zero),
		.mismatches     (mismatches),
		.awaiting       (awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Offers one request and returns at the edge where it is taken. The gap before it is
	// drawn per request; in steady stretches there is none. Valid is only lowered when a
	// gap follows, so a back-to-back request never sees valid dropped and raised at once.
	task automatic send_request(input div_op_t o, input logic [W-1:0] a,
			input logic [W-1:0] b);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0)
			tx_steady = !tx_steady;
		gap = tx_steady ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		op <= o;
		dividend <= a;
		divisor <= b;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// Values at the edges of both the unsigned and the two's complement ranges.
	function automatic logic [W-1:0] corner_value();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return {{(W-1){1'b0}}, 1'b1};
			2: return '1;
			3: return {1'b1, {(W-1){1'b0}}};
			4: return {1'b0, {(W-1){1'b1}}};
			5: return {{(W-1){1'b1}}, 1'b0};
			default: return {{(W-1){1'b0}}, 1'b1} << $urandom_range(0, W-1);
		endcase
	endfunction

	// Random requests: full-range operands most often, a good share with divisors of random
	// length so that quotients of every size show up, plus corners and zero divisors.
	task automatic send_random();
		div_op_t      o;
		logic [W-1:0] a;
		logic [W-1:0] b;
		int unsigned  pick;
		o = div_op_t'($urandom_range(0, 1));
		a = $urandom();
		b = $urandom();
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			b = '0;
		end else if (pick < 15) begin
			a = corner_value();
			b = corner_value();
		end else if (pick < 55) begin
			b = b >> $urandom_range(0, W-1);
			if ($urandom_range(0, 1) == 1)
				b = -b;
		end
		send_request(o, a, b);
	endtask

	// Receiver: holds off a drawn number of cycles before each response, with steady
	// stretches of none, and once for a long while so that the divider backs up into
	// its request side while the sender keeps offering.
	initial begin : response_sink
		int unsigned wait_len;
		int          taken;
		bit          rx_steady;
		taken = 0;
		rx_steady = 1'b0;
		rsp_stall <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_steady = !rx_steady;
			wait_len = rx_steady ? 0 : $urandom_range(0, 14);
			if (taken == HOLD_AT)
				wait_len = HOLD_CYCLES;
			if (wait_len != 0) begin
				rsp_stall <= 1'b1;
				repeat (wait_len) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			taken++;
		end
	end

	// Watchdog: any stretch with no handshake on either side longer than the limit means
	// the divider has hung or lost a response.
	initial idle_run = 0;
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		tx_steady = 1'b0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		op <= OP_UNSIGNED;
		dividend <= '0;
		divisor <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: unsigned extremes, zero divisors in both modes, every sign
		// combination in signed mode, and the most negative value over minus one, which
		// wraps back to itself.
		send_request(OP_UNSIGNED, 32'h0000_0000, 32'h0000_0001);
		send_request(OP_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0001);
		send_request(OP_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_UNSIGNED, 32'h0000_0001, 32'hFFFF_FFFF);
		send_request(OP_UNSIGNED, 32'h0000_0064, 32'h0000_0007);
		send_request(OP_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0002);
		send_request(OP_UNSIGNED, 32'h8000_0000, 32'h0000_0003);
		send_request(OP_UNSIGNED, 32'h5555_5555, 32'hAAAA_AAAA);
		send_request(OP_UNSIGNED, 32'h0000_3039, 32'h0000_0000);
		send_request(OP_UNSIGNED, 32'h0000_0000, 32'h0000_0000);
		send_request(OP_SIGNED,   32'h0000_0000, 32'h0000_0000);
		send_request(OP_SIGNED,   32'h8000_0000, 32'h0000_0000);
		send_request(OP_SIGNED,   32'h0000_0007, 32'h0000_0002);
		send_request(OP_SIGNED,   32'hFFFF_FFF9, 32'h0000_0002);
		send_request(OP_SIGNED,   32'h0000_0007, 32'hFFFF_FFFE);
		send_request(OP_SIGNED,   32'hFFFF_FFF9, 32'hFFFF_FFFE);
		send_request(OP_SIGNED,   32'h8000_0000, 32'hFFFF_FFFF);
		send_request(OP_SIGNED,   32'h8000_0000, 32'h0000_0001);
		send_request(OP_SIGNED,   32'h8000_0000, 32'h8000_0000);
		send_request(OP_SIGNED,   32'h7FFF_FFFF, 32'h8000_0000);
		send_request(OP_SIGNED,   32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_SIGNED,   32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_request(OP_SIGNED,   32'hAAAA_AAAA, 32'h5555_5555);

		repeat (RANDOM_ITEMS) send_random();
		req_valid <= 1'b0;

		// The checker's count of outstanding responses is registered, so the first look at it
		// comes in the cycle after the last request was taken.
		do @(posedge clk); while (awaiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/idiv_pkg.sv
rtl/idiv_dp.sv
rtl/idiv_ctrl.sv
rtl/integer_divider_signed_unsigned.sv
sim/div_op_pkg.sv
sim/div_result_checker.sv
sim/tb.sv
